FILE: rtl/csvt_pkg.sv
// Shared types, codes and byte classifiers for the CSV field tokenizer.
// No dependencies; imported by every module of the block.
package csvt_pkg;

  localparam int CSVT_OFFSET_BITS = 32;
  localparam int CSVT_COLUMN_BITS = 16;
  localparam int CSVT_LINE_BITS   = 32;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [7:0] DELIM_RESET  = 8'd44;
  localparam logic [7:0] QUOTE_RESET  = 8'd34;
  localparam logic       HEADER_RESET = 1'b1;

  typedef enum logic [1:0] {
    REG_DELIMITER = 2'd0,
    REG_QUOTE     = 2'd1,
    REG_HEADER    = 2'd2
  } csvt_reg_e;

  typedef enum logic [1:0] {
    KIND_NULL = 2'd0,
    KIND_INT  = 2'd1,
    KIND_DEC  = 2'd2,
    KIND_STR  = 2'd3
  } csvt_kind_e;

  typedef enum logic [2:0] {
    STG_LEAD  = 3'd0,
    STG_SIGN  = 3'd1,
    STG_BODY  = 3'd2,
    STG_TRAIL = 3'd3,
    STG_TEXT  = 3'd4
  } csvt_stage_e;

  typedef struct packed {
    csvt_stage_e stg;
    logic        dot;
    logic        dig;
  } csvt_num_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
  } csvt_beat_t;

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] quote;
    logic       header;
  } csvt_cfg_t;

  localparam csvt_num_t NUM_RESET = '{stg: STG_LEAD, dot: 1'b0, dig: 1'b0};

  function automatic logic is_ws(logic [7:0] b);
    return (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C) || (b == 8'h20);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic csvt_num_t num_after_sign(csvt_num_t s, logic [7:0] b);
    csvt_num_t r;
    r = s;
    if (is_digit(b)) begin
      r.dig = 1'b1;
      r.stg = STG_BODY;
    end else if (b == CH_DOT) begin
      r.dot = 1'b1;
      r.stg = STG_BODY;
    end else begin
      r.stg = STG_TEXT;
    end
    return r;
  endfunction

  function automatic csvt_num_t num_take(csvt_num_t s, logic [7:0] b);
    csvt_num_t r;
    r = s;
    case (s.stg)
      STG_LEAD: begin
        if (is_ws(b)) begin
          r = s;
        end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
          r.stg = STG_SIGN;
        end else begin
          r = num_after_sign(s, b);
        end
      end
      STG_SIGN: r = num_after_sign(s, b);
      STG_BODY: begin
        if (is_digit(b)) begin
          r.dig = 1'b1;
        end else if ((b == CH_DOT) && !s.dot) begin
          r.dot = 1'b1;
        end else if (is_ws(b)) begin
          r.stg = STG_TRAIL;
        end else begin
          r.stg = STG_TEXT;
        end
      end
      STG_TRAIL: begin
        if (!is_ws(b)) r.stg = STG_TEXT;
      end
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic csvt_kind_e kind_of(csvt_num_t s, logic len_zero);
    if (len_zero) return KIND_NULL;
    if (((s.stg == STG_BODY) || (s.stg == STG_TRAIL)) && s.dig) begin
      return s.dot ? KIND_DEC : KIND_INT;
    end
    return KIND_STR;
  endfunction

endpackage

FILE: rtl/csvt_in_reg.sv
// Input stage register: holds one accepted byte beat for the parse stage.
// Depends on csvt_pkg for the beat type.
module csvt_in_reg
  import csvt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  csvt_beat_t beat_i,
  input  logic       adv_ok_i,
  output logic       s1_valid_o,
  output csvt_beat_t s1_beat_o
);

  logic       valid_q;
  csvt_beat_t beat_q;

  assign in_stall_o = valid_q & ~adv_ok_i;
  assign s1_valid_o = valid_q;
  assign s1_beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      beat_q <= beat_i;
    end
  end

endmodule

FILE: rtl/csvt_parser.sv
// Parse stage: line and field state, counters and the result of one byte.
// Depends on csvt_pkg for codes, classifiers and the beat and config types.
module csvt_parser
  import csvt_pkg::*;
#(
  parameter int OFFSET_BITS = CSVT_OFFSET_BITS,
  parameter int COLUMN_BITS = CSVT_COLUMN_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  csvt_beat_t                beat_i,
  input  csvt_cfg_t                 cfg_i,
  output logic                      res_valid_o,
  output logic                      res_has_o,
  output logic [OFFSET_BITS-1:0]    res_off_o,
  output logic [OFFSET_BITS-1:0]    res_len_o,
  output logic [COLUMN_BITS-1:0]    res_col_o,
  output logic [CSVT_LINE_BITS-1:0] res_line_o,
  output csvt_kind_e                res_kind_o,
  output logic                      res_quoted_o,
  output logic                      res_endl_o,
  output logic                      res_header_o
);

  typedef enum logic [2:0] {
    MODE_FIELD_START   = 3'd0,
    MODE_UNQUOTED      = 3'd1,
    MODE_QUOTED        = 3'd2,
    MODE_QUOTE_PENDING = 3'd3,
    MODE_AFTER_CLOSE   = 3'd4
  } mode_e;

  localparam logic [OFFSET_BITS-1:0]    LEN_MAX  = '1;
  localparam logic [COLUMN_BITS-1:0]    COL_MAX  = '1;
  localparam logic [CSVT_LINE_BITS-1:0] LINE_MAX = '1;

  mode_e                     mode_q, mode_d, mode_w;
  logic [OFFSET_BITS-1:0]    pos_q, pos_d;
  logic [OFFSET_BITS-1:0]    start_q, start_d, start_w;
  logic [OFFSET_BITS-1:0]    len_q, len_d, len_w, len_inc1, len_inc2;
  logic [COLUMN_BITS-1:0]    col_q, col_d;
  logic [CSVT_LINE_BITS-1:0] line_q, line_d;
  csvt_num_t                 num_q, num_d, num_w;
  logic                      first_done_q, first_done_d;
  logic                      open_q, open_d;
  logic [7:0]                b;
  logic                      is_nl, emit_f, close_f, field_f;

  assign b        = beat_i.data;
  assign is_nl    = (b == CH_LF) || (b == CH_CR);
  assign len_inc1 = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
  assign len_inc2 = (len_inc1 == LEN_MAX) ? len_inc1 : len_inc1 + 1'b1;

  always_comb begin
    mode_w  = mode_q;
    start_w = start_q;
    len_w   = len_q;
    num_w   = num_q;
    emit_f  = 1'b0;
    if (!is_nl) begin
      unique case (mode_q)
        MODE_FIELD_START: begin
          if (is_ws(b)) begin
            mode_w = MODE_FIELD_START;
          end else if (b == cfg_i.quote) begin
            start_w = pos_q + 1'b1;
            len_w   = '0;
            num_w   = NUM_RESET;
            mode_w  = MODE_QUOTED;
          end else if (b == cfg_i.delim) begin
            start_w = pos_q;
            len_w   = '0;
            num_w   = NUM_RESET;
            mode_w  = MODE_UNQUOTED;
            emit_f  = 1'b1;
          end else begin
            start_w = pos_q;
            len_w   = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
            num_w   = num_take(NUM_RESET, b);
            mode_w  = MODE_UNQUOTED;
          end
        end
        MODE_UNQUOTED: begin
          if (b == cfg_i.delim) begin
            emit_f = 1'b1;
          end else begin
            len_w = len_inc1;
            num_w = num_take(num_q, b);
          end
        end
        MODE_QUOTED: begin
          if (b == cfg_i.quote) begin
            mode_w = MODE_QUOTE_PENDING;
          end else begin
            len_w = len_inc1;
            num_w = num_take(num_q, b);
          end
        end
        MODE_QUOTE_PENDING: begin
          if (b == cfg_i.quote) begin
            len_w  = len_inc2;
            num_w  = num_take(num_take(num_q, b), b);
            mode_w = MODE_QUOTED;
          end else begin
            mode_w = MODE_AFTER_CLOSE;
            emit_f = (b == cfg_i.delim);
          end
        end
        default: begin
          mode_w = MODE_AFTER_CLOSE;
          emit_f = (b == cfg_i.delim);
        end
      endcase
    end
  end

  assign close_f = is_nl ? open_q : (beat_i.eod & ~emit_f);
  assign field_f = emit_f | (close_f & (mode_w != MODE_FIELD_START));

  assign res_valid_o  = fire_i & (emit_f | close_f);
  assign res_has_o    = field_f;
  assign res_off_o    = field_f ? start_w : '0;
  assign res_len_o    = field_f ? len_w : '0;
  assign res_col_o    = field_f ? col_q : '0;
  assign res_line_o   = line_q;
  assign res_kind_o   = field_f ? kind_of(num_w, len_w == '0) : KIND_NULL;
  assign res_quoted_o = field_f & (mode_w >= MODE_QUOTED);
  assign res_endl_o   = close_f | beat_i.eod;
  assign res_header_o = cfg_i.header & ~first_done_q;

  always_comb begin
    mode_d       = mode_w;
    pos_d        = pos_q + 1'b1;
    start_d      = start_w;
    len_d        = len_w;
    num_d        = num_w;
    col_d        = col_q;
    line_d       = line_q;
    first_done_d = first_done_q;
    open_d       = open_q | ~is_nl;
    if (emit_f) begin
      col_d  = (col_q == COL_MAX) ? col_q : col_q + 1'b1;
      mode_d = MODE_FIELD_START;
    end
    if (close_f) begin
      line_d       = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
      first_done_d = 1'b1;
      open_d       = 1'b0;
      col_d        = '0;
      mode_d       = MODE_FIELD_START;
    end
    if (beat_i.eod) begin
      mode_d       = MODE_FIELD_START;
      pos_d        = '0;
      start_d      = '0;
      len_d        = '0;
      num_d        = NUM_RESET;
      col_d        = '0;
      line_d       = '0;
      first_done_d = 1'b0;
      open_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_FIELD_START;
      pos_q        <= '0;
      start_q      <= '0;
      len_q        <= '0;
      num_q        <= NUM_RESET;
      col_q        <= '0;
      line_q       <= '0;
      first_done_q <= 1'b0;
      open_q       <= 1'b0;
    end else if (fire_i) begin
      mode_q       <= mode_d;
      pos_q        <= pos_d;
      start_q      <= start_d;
      len_q        <= len_d;
      num_q        <= num_d;
      col_q        <= col_d;
      line_q       <= line_d;
      first_done_q <= first_done_d;
      open_q       <= open_d;
    end
  end

  a_eod_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && beat_i.eod |=> pos_q == '0 && !open_q && line_q == '0)
    else $error("end of data did not restart the stream");

  a_closed_line_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> mode_q == MODE_FIELD_START)
    else $error("field in progress outside an open line");

  a_bare_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_has_o |-> res_endl_o && res_len_o == '0 && !res_quoted_o)
    else $error("bare line end carries field data");

  a_result_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> fire_i)
    else $error("result without an advancing beat");

endmodule

FILE: rtl/csv_field_tokenizer.sv
// Streaming CSV tokenizer: one byte beat in per cycle unless stalled, at most one
// field or bare line-end result out per beat. A beat passes through the input
// register, then the single parse stage into the result register; the sustained
// rate is one beat per clock while no result is held. A held result stalls the
// parse stage, and the input with it once the input register holds a beat. No
// clearing pass after reset. Depends on csvt_pkg, csvt_in_reg and csvt_parser.
module csv_field_tokenizer
  import csvt_pkg::*;
#(
  parameter int OFFSET_BITS = CSVT_OFFSET_BITS,
  parameter int COLUMN_BITS = CSVT_COLUMN_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [7:0]                cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      end_of_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      has_field_o,
  output logic [OFFSET_BITS-1:0]    field_offset_o,
  output logic [OFFSET_BITS-1:0]    field_length_o,
  output logic [COLUMN_BITS-1:0]    column_number_o,
  output logic [CSVT_LINE_BITS-1:0] line_number_o,
  output logic [1:0]                value_kind_o,
  output logic                      was_quoted_o,
  output logic                      ends_line_o,
  output logic                      header_row_o
);

  csvt_cfg_t                 cfg_q;
  csvt_beat_t                in_beat, s1_beat;
  logic                      s1_valid, adv_ok, fire;
  logic                      res_valid, res_has, res_quoted, res_endl, res_header;
  logic [OFFSET_BITS-1:0]    res_off, res_len;
  logic [COLUMN_BITS-1:0]    res_col;
  logic [CSVT_LINE_BITS-1:0] res_line;
  csvt_kind_e                res_kind;

  logic                      out_valid_q;
  logic                      has_q, quoted_q, endl_q, header_q;
  logic [OFFSET_BITS-1:0]    off_q, len_q;
  logic [COLUMN_BITS-1:0]    col_q;
  logic [CSVT_LINE_BITS-1:0] line_q;
  logic [1:0]                kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim  <= DELIM_RESET;
      cfg_q.quote  <= QUOTE_RESET;
      cfg_q.header <= HEADER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DELIMITER: cfg_q.delim  <= cfg_data_i;
        REG_QUOTE:     cfg_q.quote  <= cfg_data_i;
        REG_HEADER:    cfg_q.header <= cfg_data_i[0];
        default:       cfg_q        <= cfg_q;
      endcase
    end
  end

  assign in_beat = '{data: data_byte_i, eod: end_of_data_i};
  assign adv_ok  = ~(out_valid_q & out_stall_i);
  assign fire    = s1_valid & adv_ok;

  csvt_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .beat_i     (in_beat),
    .adv_ok_i   (adv_ok),
    .s1_valid_o (s1_valid),
    .s1_beat_o  (s1_beat)
  );

  csvt_parser #(
    .OFFSET_BITS (OFFSET_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .beat_i       (s1_beat),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_has_o    (res_has),
    .res_off_o    (res_off),
    .res_len_o    (res_len),
    .res_col_o    (res_col),
    .res_line_o   (res_line),
    .res_kind_o   (res_kind),
    .res_quoted_o (res_quoted),
    .res_endl_o   (res_endl),
    .res_header_o (res_header)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_ok) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      has_q    <= res_has;
      off_q    <= res_off;
      len_q    <= res_len;
      col_q    <= res_col;
      line_q   <= res_line;
      kind_q   <= res_kind;
      quoted_q <= res_quoted;
      endl_q   <= res_endl;
      header_q <= res_header;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign has_field_o     = has_q;
  assign field_offset_o  = off_q;
  assign field_length_o  = len_q;
  assign column_number_o = col_q;
  assign line_number_o   = line_q;
  assign value_kind_o    = kind_q;
  assign was_quoted_o    = quoted_q;
  assign ends_line_o     = endl_q;
  assign header_row_o    = header_q;

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(off_q) && $stable(len_q))
    else $error("held result beat overwritten");

  a_fire_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !(out_valid_q && out_stall_i))
    else $error("result produced into an occupied slot");

  a_stall_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid && out_valid_q)
    else $error("input stalled with a free pipeline");

endmodule
